[rtl/socks5_udp_header_deframer_core_assert.svh]
// Assertion macros shared by the deframer modules.
// Each module that uses them must have clk and rst in scope.
`ifndef SOCKS5_UDP_HEADER_DEFRAMER_CORE_ASSERT_SVH
`define SOCKS5_UDP_HEADER_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, idle during reset.
`define SUDD_CHECK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, idle during reset.
`define SUDD_CHECK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/sudd_pkg.sv]
package sudd_pkg;

  // Header layout
  localparam logic [4:0] HDR_LEN_V4     = 5'd10;
  localparam logic [4:0] HDR_LEN_V6     = 5'd22;
  localparam logic [4:0] POS_RSV_LAST   = 5'd1;
  localparam logic [4:0] POS_FRAG       = 5'd2;
  localparam logic [4:0] POS_ATYP       = 5'd3;
  localparam logic [4:0] POS_ADDR_FIRST = 5'd4;
  localparam logic [4:0] POS_MAX        = 5'd31;

  // Address type codes
  localparam logic [7:0] ATYP_V4     = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN = 8'h03;
  localparam logic [7:0] ATYP_V6     = 8'h04;

  // Result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_SHORT   = 3'd1;
  localparam logic [2:0] ST_RSV     = 3'd2;
  localparam logic [2:0] ST_FRAG    = 3'd3;
  localparam logic [2:0] ST_DOMAIN  = 3'd4;
  localparam logic [2:0] ST_BADTYPE = 3'd5;
  localparam logic [2:0] ST_V6SHORT = 3'd6;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_datagram;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic        family;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [15:0] source_port;
    logic [7:0]  payload_byte;
    logic        last;
  } out_word_t;

  // Actions handed from front to back
  typedef enum logic [2:0] {
    OP_ADDR,
    OP_PORT,
    OP_HEADER,
    OP_PAYLOAD,
    OP_REJECT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] status;
    logic       family;
    logic [7:0] data;
    logic       last;
  } q_word_t;

endpackage

[rtl/socks5_udp_header_deframer_core.sv]
// SOCKS5 UDP header deframer. Feed a relayed datagram one byte per word on the
// item channel, with end_of_datagram on its final byte. The block checks the
// reserved and fragment bytes and the address type (IPv4 or IPv6 only), and
// delivers one header word carrying family, address and source port, followed
// by one word per payload byte; a rejected datagram yields a single reject word
// with its status on the final byte and nothing before it. One byte is taken
// every clock cycle for as long as the result side keeps up: the front
// classifies each byte combinationally and the back has one output register.
// A result word passes through a queue slot before it is loaded into the output
// register. Between the two halves sits a queue of QUEUE_DEPTH words, so a
// stall on the result side holds item_ready low only once that queue and the
// output register are full.
module socks5_udp_header_deframer_core #(
  parameter int QUEUE_DEPTH = sudd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  sudd_pkg::in_word_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output sudd_pkg::out_word_t result
);

  // Front to queue
  logic              q_full;
  logic              q_push;
  sudd_pkg::q_word_t q_push_word;
  // Queue to back
  logic              q_pop;
  logic              q_valid;
  sudd_pkg::q_word_t q_pop_word;

  // Classify each byte and drop those that need no action
  sudd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_word     (q_push_word)
  );

  // Hold actions while the result side stalls
  sudd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (q_push_word),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_word  (q_pop_word)
  );

  // Gather address and port, then build the result words
  sudd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_word       (q_pop_word),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

[rtl/sudd_front.sv]
module sudd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  sudd_pkg::in_word_t item,
  input  logic               q_full,
  output logic               q_push,
  output sudd_pkg::q_word_t  q_word
);

  logic [4:0] pos;
  logic [4:0] pos_next;
  logic       is_ipv6;
  logic       is_ipv6_next;
  logic [2:0] pend;
  logic [2:0] pend_next;
  logic       in_payload;
  logic       in_payload_next;
  logic       has_op;
  logic       clr;
  logic       accept;
  logic [4:0] hdr_last;
  logic [4:0] port_first;
  logic       shift_addr;
  logic       shift_port;

  assign item_ready = !q_full;
  assign accept     = item_valid && item_ready;
  assign q_push     = accept && has_op;

  always_comb begin
    pos_next        = pos;
    is_ipv6_next    = is_ipv6;
    pend_next       = pend;
    in_payload_next = in_payload;
    has_op          = 1'b0;
    clr             = 1'b0;
    q_word          = '0;
    q_word.op       = sudd_pkg::OP_ADDR;
    q_word.data     = item.data_byte;
    hdr_last        = '0;
    port_first      = '0;
    shift_addr      = 1'b0;
    shift_port      = 1'b0;
    if (in_payload) begin
      has_op      = 1'b1;
      q_word.op   = sudd_pkg::OP_PAYLOAD;
      q_word.last = item.end_of_datagram;
      clr         = item.end_of_datagram;
    end else begin
      if (pos <= sudd_pkg::POS_RSV_LAST) begin
        if (item.data_byte != '0 && pend == sudd_pkg::ST_OK) pend_next = sudd_pkg::ST_RSV;
      end else if (pos == sudd_pkg::POS_FRAG) begin
        if (item.data_byte != '0 && pend == sudd_pkg::ST_OK) pend_next = sudd_pkg::ST_FRAG;
      end else if (pos == sudd_pkg::POS_ATYP) begin
        if (item.data_byte == sudd_pkg::ATYP_V6) is_ipv6_next = 1'b1;
        if (pend == sudd_pkg::ST_OK) begin
          if (item.data_byte == sudd_pkg::ATYP_DOMAIN) begin
            pend_next = sudd_pkg::ST_DOMAIN;
          end else if (item.data_byte != sudd_pkg::ATYP_V4 &&
                       item.data_byte != sudd_pkg::ATYP_V6) begin
            pend_next = sudd_pkg::ST_BADTYPE;
          end
        end
      end

      hdr_last   = is_ipv6_next ? (sudd_pkg::HDR_LEN_V6 - 5'd1) : (sudd_pkg::HDR_LEN_V4 - 5'd1);
      port_first = hdr_last - 5'd1;
      shift_addr = (pos >= sudd_pkg::POS_ADDR_FIRST) && (pos < port_first);
      shift_port = (pos >= port_first) && (pos <= hdr_last);

      if (pos == hdr_last && pend_next == sudd_pkg::ST_OK) begin
        has_op        = 1'b1;
        q_word.op     = sudd_pkg::OP_HEADER;
        q_word.family = is_ipv6_next;
        q_word.last   = item.end_of_datagram;
        clr           = item.end_of_datagram;
        in_payload_next = !item.end_of_datagram;
      end else if (item.end_of_datagram) begin
        has_op      = 1'b1;
        q_word.op   = sudd_pkg::OP_REJECT;
        q_word.last = 1'b1;
        clr         = 1'b1;
        if (pos < sudd_pkg::HDR_LEN_V4 - 5'd1) begin
          q_word.status = sudd_pkg::ST_SHORT;
        end else if (pend_next != sudd_pkg::ST_OK) begin
          q_word.status = pend_next;
        end else begin
          q_word.status = sudd_pkg::ST_V6SHORT;
        end
      end else begin
        if (shift_addr) begin
          has_op    = 1'b1;
          q_word.op = sudd_pkg::OP_ADDR;
        end else if (shift_port) begin
          has_op    = 1'b1;
          q_word.op = sudd_pkg::OP_PORT;
        end
        if (pos != sudd_pkg::POS_MAX) pos_next = pos + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      is_ipv6    <= 1'b0;
      pend       <= sudd_pkg::ST_OK;
      in_payload <= 1'b0;
    end else if (accept) begin
      if (clr) begin
        pos        <= '0;
        is_ipv6    <= 1'b0;
        pend       <= sudd_pkg::ST_OK;
        in_payload <= 1'b0;
      end else begin
        pos        <= pos_next;
        is_ipv6    <= is_ipv6_next;
        pend       <= pend_next;
        in_payload <= in_payload_next;
      end
    end
  end

endmodule

[rtl/sudd_queue.sv]
`include "socks5_udp_header_deframer_core_assert.svh"

module sudd_queue #(
  parameter int DEPTH = sudd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sudd_pkg::q_word_t push_word,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output sudd_pkg::q_word_t pop_word
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sudd_pkg::q_word_t slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_word  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `SUDD_CHECK_IMP(a_count_bound, 1'b1, count <= CNT_W'(DEPTH), "queue fill beyond depth")
  `SUDD_CHECK_IMP(a_pop_nonempty, pop, count != '0, "pop from empty queue")
  `SUDD_CHECK_NXT(a_push_grows, push && !pop, count == $past(count) + 1'b1, "fill count lost a push")

endmodule

[rtl/sudd_back.sv]
`include "socks5_udp_header_deframer_core_assert.svh"

module sudd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  sudd_pkg::q_word_t   q_word,
  output logic                q_pop,
  output logic                result_valid,
  input  logic                result_ready,
  output sudd_pkg::out_word_t result
);

  logic [63:0]         addr_hi;
  logic [63:0]         addr_lo;
  logic [15:0]         port;
  logic [15:0]         port_next;
  logic                is_shift;
  logic                emits;
  sudd_pkg::out_word_t result_next;

  assign is_shift  = (q_word.op == sudd_pkg::OP_ADDR) || (q_word.op == sudd_pkg::OP_PORT);
  assign q_pop     = q_valid && (is_shift || !result_valid || result_ready);
  assign emits     = q_pop && !is_shift;
  assign port_next = {port[7:0], q_word.data};

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_hi      <= '0;
      addr_lo      <= '0;
      port         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (emits) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
      if (q_pop) begin
        case (q_word.op)
          sudd_pkg::OP_ADDR: begin
            addr_hi <= {addr_hi[55:0], addr_lo[63:56]};
            addr_lo <= {addr_lo[55:0], q_word.data};
          end
          sudd_pkg::OP_PORT: port <= port_next;
          sudd_pkg::OP_HEADER, sudd_pkg::OP_REJECT: begin
            addr_hi <= '0;
            addr_lo <= '0;
            port    <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    result_next      = '0;
    result_next.last = q_word.last;
    case (q_word.op)
      sudd_pkg::OP_HEADER: begin
        result_next.kind         = sudd_pkg::KIND_HEADER;
        result_next.family       = q_word.family;
        result_next.address_high = addr_hi;
        result_next.address_low  = addr_lo;
        result_next.source_port  = port_next;
      end
      sudd_pkg::OP_PAYLOAD: begin
        result_next.kind         = sudd_pkg::KIND_PAYLOAD;
        result_next.payload_byte = q_word.data;
      end
      default: begin
        result_next.kind   = sudd_pkg::KIND_REJECT;
        result_next.status = q_word.status;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emits) result <= result_next;
  end

  `SUDD_CHECK_IMP(a_reject_last, result_valid && result.kind == sudd_pkg::KIND_REJECT,
                  result.last, "reject word without last")
  `SUDD_CHECK_IMP(a_addr_only_hdr, result_valid && result.kind != sudd_pkg::KIND_HEADER,
                  result.address_high == '0 && result.address_low == '0, "stray address bits")
  `SUDD_CHECK_IMP(a_ok_status, result_valid && result.kind != sudd_pkg::KIND_REJECT,
                  result.status == sudd_pkg::ST_OK, "status set on a non-reject word")

endmodule
